// ===== sv/sha_pkg.sv =====
// sha-256 stream hash package: command codes, round constants, initial hash
// values and the round and message schedule helper functions
// no dependencies
`timescale 1ns / 1ps

package sha_pkg;

    typedef enum logic [1:0] {
        CMD_ABSORB  = 2'd0,
        CMD_FINISH  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // block buffer holds sixteen 32-bit schedule words, bytes packed big-endian
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned ROUNDS    = 64;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] hash_t;

    // datapath commands from the controller
    typedef struct packed {
        logic       buf_write;   // write byte at fill position
        logic [7:0] buf_byte;
        logic [5:0] buf_pos;
        logic       clear_low;   // zero bytes 0..55 (second pad block)
        logic       write_len;   // write length into bytes 56..63
        logic       round_init;  // load working vars from chain
        logic       round_step;  // run one round
        logic       chain_add;   // fold working vars into chain
        logic       chain_reset; // load initial hash values
    } dp_cmd_t;

    function automatic word_t ror(input word_t x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t round_k(input logic [5:0] i);
        word_t k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[i];
    endfunction

    function automatic hash_t init_h();
        hash_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        init_h = h;
    endfunction

endpackage

// ===== sv/sha_if.sv =====
// valid/ready channel interfaces for the hash core
// depends on sha_pkg
`timescale 1ns / 1ps

interface sha_in_if;
    logic         valid;
    logic         ready;
    sha_pkg::cmd_t command;
    logic [7:0]   data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha_datapath.sv =====
// compression datapath: block buffer as a 16-word shift line, working
// variables, chaining words; one round per cycle under controller command
// depends on sha_pkg
`timescale 1ns / 1ps

module sha_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::dp_cmd_t  cmd,
    input  logic [63:0]       length_bits,
    input  logic [5:0]        round_idx,
    input  logic [2:0]        rd_index,
    output sha_pkg::word_t    rd_word
);

    sha_pkg::word_t w_reg [0:15];
    sha_pkg::hash_t v_reg;
    sha_pkg::hash_t h_reg;

    // message schedule and round function: next word from the shift line, t1 and t2
    sha_pkg::word_t s0, s1, w_new, t1, t2;
    always_comb
    begin
        s0 = sha_pkg::ror(w_reg[1], 7) ^ sha_pkg::ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::ror(w_reg[14], 17) ^ sha_pkg::ror(w_reg[14], 19)
            ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7]
            + (sha_pkg::ror(v_reg[4], 6) ^ sha_pkg::ror(v_reg[4], 11)
               ^ sha_pkg::ror(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + sha_pkg::round_k(round_idx) + w_reg[0];
        t2 = (sha_pkg::ror(v_reg[0], 2) ^ sha_pkg::ror(v_reg[0], 13)
              ^ sha_pkg::ror(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // buffer words: byte writes, padding, and shift during rounds
    always_ff @(posedge clk)
    begin
        if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        else
        begin
            if (cmd.buf_write)
            begin
                case (cmd.buf_pos[1:0])
                    2'd0:    w_reg[cmd.buf_pos[5:2]][31:24] <= cmd.buf_byte;
                    2'd1:    w_reg[cmd.buf_pos[5:2]][23:16] <= cmd.buf_byte;
                    2'd2:    w_reg[cmd.buf_pos[5:2]][15:8]  <= cmd.buf_byte;
                    default: w_reg[cmd.buf_pos[5:2]][7:0]   <= cmd.buf_byte;
                endcase
            end
            if (cmd.clear_low)
            begin
                for (int i = 0; i < 14; i++)
                begin
                    w_reg[i] <= '0;
                end
            end
            if (cmd.write_len)
            begin
                w_reg[14] <= length_bits[63:32];
                w_reg[15] <= length_bits[31:0];
            end
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.round_init)
        begin
            v_reg <= h_reg;
        end
        else if (cmd.round_step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= sha_pkg::init_h();
        end
        else if (cmd.chain_reset)
        begin
            h_reg <= sha_pkg::init_h();
        end
        else if (cmd.chain_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign rd_word = h_reg[rd_index];

endmodule

// ===== sv/sha_ctrl.sv =====
// controller: command decode, byte fill, padding sequence, round counter,
// and digest word output register
// depends on sha_pkg and sha_if
`timescale 1ns / 1ps

module sha_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    sha_in_if.sink           in_ch,
    sha_out_if.source        out_ch,
    output sha_pkg::dp_cmd_t cmd,
    output logic [63:0]      length_bits,
    output logic [5:0]       round_idx,
    output logic [2:0]       rd_index,
    input  sha_pkg::word_t   rd_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_ADD,
        ST_PAD2,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        done_reg, done_next;
    logic        final_reg, final_next;   // compression is the length block
    logic        second_reg, second_next; // another length block follows
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    sha_pkg::word_t oword_reg, oword_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        olast_reg, olast_next;

    logic        acc;
    logic        out_free;

    assign out_free   = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign acc        = in_ch.valid && in_ch.ready;

    assign out_ch.valid       = ovalid_reg;
    assign out_ch.digest_word = oword_reg;
    assign out_ch.word_index  = oidx_reg;
    assign out_ch.last_word   = olast_reg;
    assign round_idx          = round_reg;
    assign rd_index           = idx_reg;
    assign length_bits        = bits_reg;

    // next-state and command logic
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        done_next   = done_reg;
        final_next  = final_reg;
        second_next = second_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        oword_next  = oword_reg;
        oidx_next   = oidx_reg;
        olast_next  = olast_reg;
        cmd         = '0;
        cmd.buf_byte = in_ch.data_byte;
        cmd.buf_pos  = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (in_ch.command)
                        sha_pkg::CMD_ABSORB:
                        begin
                            if (!done_reg)
                            begin
                                cmd.buf_write = 1'b1;
                                fill_next     = fill_reg + 6'd1;
                                if (fill_reg == 6'd63)
                                begin
                                    bits_next  = bits_reg + 64'd512;
                                    final_next = 1'b0;
                                    state_next = ST_INIT;
                                end
                            end
                        end
                        sha_pkg::CMD_FINISH:
                        begin
                            idx_next = 3'd0;
                            if (done_reg)
                            begin
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                // pad byte, then zero the block up to the length field or the block end
                                cmd.buf_byte  = sha_pkg::PAD_BYTE;
                                cmd.buf_write = 1'b1;
                                bits_next = bits_reg + {55'd0, fill_reg, 3'd0};
                                done_next = 1'b1;
                                state_next = ST_PAD2;
                                fill_next  = fill_reg + 6'd1;
                                second_next = (fill_reg >= 6'd56);
                            end
                        end
                        sha_pkg::CMD_RESTART:
                        begin
                            cmd.chain_reset = 1'b1;
                            fill_next = '0;
                            bits_next = '0;
                            done_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PAD2:
            begin
                // zero bytes one per cycle up to the block end or length field
                if (fill_reg == 6'd0 || (!second_reg && fill_reg == 6'd56))
                begin
                    if (!second_reg)
                    begin
                        cmd.write_len = 1'b1;
                        final_next    = 1'b1;
                    end
                    else
                    begin
                        final_next = 1'b0;
                    end
                    state_next = ST_INIT;
                end
                else
                begin
                    cmd.buf_byte  = 8'd0;
                    cmd.buf_write = 1'b1;
                    fill_next     = fill_reg + 6'd1;
                end
            end
            ST_INIT:
            begin
                cmd.round_init = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.chain_add = 1'b1;
                if (!done_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (second_reg && !final_reg)
                begin
                    // second padded block: zeros then length
                    cmd.clear_low = 1'b1;
                    cmd.write_len = 1'b1;
                    second_next   = 1'b0;
                    final_next    = 1'b1;
                    state_next    = ST_INIT;
                end
                else
                begin
                    fill_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = rd_word;
                    oidx_next   = idx_reg;
                    olast_next  = (idx_reg == 3'd7);
                    idx_next    = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            done_reg   <= 1'b0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            round_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            done_reg   <= done_next;
            final_reg  <= final_next;
            second_reg <= second_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        oword_reg <= oword_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

endmodule

// ===== sv/sha256_stream_hash_core.sv =====
// sha-256 stream hash core top level: controller plus compression datapath
// depends on sha_pkg, sha_if, sha_ctrl, sha_datapath
`timescale 1ns / 1ps

// Byte-serial SHA-256 taking one byte per absorb command; the 64th byte of a
// block starts a compression (load, 64 rounds at one round per cycle, chain
// add) during which ready is low, so no new byte is taken until it ends.
// Finish pads one zero byte per cycle, then runs one or two compressions
// and sends eight digest words, one per cycle while the sink is ready. A
// repeated finish only re-sends the digest. Restart and the unused command
// give no word.
module sha256_stream_hash_core (
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    sha_pkg::dp_cmd_t cmd;
    logic [63:0]      length_bits;
    logic [5:0]       round_idx;
    logic [2:0]       rd_index;
    sha_pkg::word_t   rd_word;

    sha_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cmd         (cmd),
        .length_bits (length_bits),
        .round_idx   (round_idx),
        .rd_index    (rd_index),
        .rd_word     (rd_word)
    );

    sha_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .length_bits (length_bits),
        .round_idx   (round_idx),
        .rd_index    (rd_index),
        .rd_word     (rd_word)
    );

endmodule

// ===== sv/sha_checker.sv =====
// port-level checks for the hash core, bound to the top level
// depends on sha_if
`timescale 1ns / 1ps

module sha_checker (
    input logic        clk,
    input logic        rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);

    // a held word does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word))
        else $error("digest word changed while stalled");

    // last mark only on the eighth word
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
        else $error("last mark on wrong word");

    // words come in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last_word |=>
        !out_ch.valid || out_ch.word_index == $past(out_ch.word_index) + 3'd1)
        else $error("digest word order broken");

    // no input is taken while digest words are going out
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last_word |-> !in_ch.ready)
        else $error("input accepted mid digest");

endmodule

bind sha256_stream_hash_core sha_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);
